// ===== hw/rtl/cses_pkg.sv =====
// Shared types, field positions and event codes for the charger status event classifier.
package cses_pkg;

    localparam int unsigned ALERT_W    = 24;
    localparam int unsigned BATTERY_W  = 8;
    localparam int unsigned EVENT_W    = 3;
    localparam int unsigned IN_USER_W  = 3;
    localparam int unsigned OUT_USER_W = 5;

    // Alert word layout
    localparam int unsigned IRQ_LSB     = 20;
    localparam int unsigned IRQ_MSB     = 23;
    localparam int unsigned BAT_LSB     = 8;
    localparam int unsigned BAT_MSB     = 15;
    localparam int unsigned DEV_BIT     = 7;
    localparam int unsigned CHG_BIT     = 6;
    localparam int unsigned PROF_LSB    = 4;
    localparam int unsigned PROF_MSB    = 5;
    localparam logic [3:0]  IRQ_CHIP_RESET = 4'd9;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 3'd0,
        EV_RESET     = 3'd1,
        EV_CONNECTED = 3'd2,
        EV_LOST      = 3'd3,
        EV_UPDATE    = 3'd4,
        EV_STARTED   = 3'd5,
        EV_STOPPED   = 3'd6
    } t_event;

    typedef struct packed {
        logic [ALERT_W-1:0] alert_word;
        logic               host_in_reset;
        logic               read_failed;
        logic               clear_status;
    } t_item;

    typedef struct packed {
        t_event               event_code;
        logic [BATTERY_W-1:0] battery_level;
        logic                 battery_reported;
        logic                 read_error;
    } t_result;

endpackage

// ===== hw/rtl/charger_status_event_classifier.sv =====
// Top level of the charger status event classifier.
//
// One word on the slave stream carries a sampled 24-bit charger alert word in
// tdata and three flags in tuser. The block compares the sample with the stored
// status word and returns one result word on the master stream: the event code,
// the battery byte of the stored word, a battery-reported flag and a read-error
// flag.
// A word passes the input register, then the result register, on its way out.
// Throughput: one word per cycle; the input register and the classify logic
// advance together, so a word is accepted in every cycle in which the result
// register is empty or is being taken.
// The stored status word is updated as each word moves into the result
// register; a clear flag zeroes it, a failed read leaves it alone.
// Reset clears both stage valids and the stored status word to zero.
// When the receiver holds m_axis_tready low, the result register holds its word,
// the input register takes at most one more word, and then s_axis_tready drops.
module charger_status_event_classifier
    import cses_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [23:0] alert_word
    input  logic [ALERT_W-1:0]    s_axis_tdata,
    // [0] host_in_reset, [1] read_failed, [2] clear_status
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] battery_level
    output logic [BATTERY_W-1:0]  m_axis_tdata,
    // [2:0] event_code, [3] battery_reported, [4] read_error
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    out_ready;
    t_result cls_result;
    t_result out_result;

    always_comb begin
        in_item.alert_word    = s_axis_tdata;
        in_item.host_in_reset = s_axis_tuser[0];
        in_item.read_failed   = s_axis_tuser[1];
        in_item.clear_status  = s_axis_tuser[2];
    end

    cses_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .i_ready (out_ready),
        .o_item  (stage_item)
    );

    cses_classify u_classify (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (stage_valid && out_ready),
        .i_item    (stage_item),
        .o_result  (cls_result)
    );

    cses_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_valid),
        .o_ready  (out_ready),
        .i_result (cls_result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = out_result.battery_level;
    assign m_axis_tuser = {out_result.read_error, out_result.battery_reported,
                           out_result.event_code};

    // Both stages come up empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !stage_valid)
        else $error("pipeline not empty after reset");

    // A failed read never reports an event or a battery level
    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_result.read_error |->
            out_result.event_code == EV_NONE && !out_result.battery_reported)
        else $error("event reported on failed read");

    // Battery is reported exactly with a charge update
    a_report_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            out_result.battery_reported == (out_result.event_code == EV_UPDATE))
        else $error("battery flag disagrees with event code");

    // A clear request yields an all-zero result
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_valid && out_ready && stage_item.clear_status |=>
            m_axis_tvalid && out_result == '0)
        else $error("clear request gave nonzero result");

endmodule

// ===== hw/rtl/cses_in_stage.sv =====
// Input register stage: captures one alert word and its flags.
module cses_in_stage
    import cses_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== hw/rtl/cses_classify.sv =====
// Stored status word and the fixed-priority event classification.
module cses_classify
    import cses_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_item   i_item,
    output t_result o_result
);

    logic [ALERT_W-1:0] r_last;
    logic [ALERT_W-1:0] n_last;
    logic [ALERT_W-1:0] cur;
    logic               pd, cd, pc, cc;
    t_event             ev;
    logic               rep;

    assign cur = i_item.alert_word;
    assign pd  = r_last[DEV_BIT];
    assign cd  = cur[DEV_BIT];
    assign pc  = r_last[CHG_BIT];
    assign cc  = cur[CHG_BIT];

    always_comb begin
        ev     = EV_NONE;
        rep    = 1'b0;
        n_last = r_last;
        if (i_item.clear_status) begin
            n_last = '0;
        end else if (!i_item.read_failed) begin
            n_last = cur;
            if (cur[IRQ_MSB:IRQ_LSB] == IRQ_CHIP_RESET) begin
                ev = EV_RESET;
            end else if (!pd && cd) begin
                ev = EV_CONNECTED;
            end else if (pd && !cd) begin
                ev = EV_LOST;
            end else if (r_last[PROF_MSB:PROF_LSB] != cur[PROF_MSB:PROF_LSB]) begin
                ev  = EV_UPDATE;
                rep = 1'b1;
            end else if (!pc && cc) begin
                ev = EV_STARTED;
            end else if (pc && !cc) begin
                ev = EV_STOPPED;
            end else if (r_last[BAT_MSB:BAT_LSB] != cur[BAT_MSB:BAT_LSB]) begin
                ev  = EV_UPDATE;
                rep = 1'b1;
            end else if (i_item.host_in_reset) begin
                ev = EV_RESET;
            end
        end
    end

    always_comb begin
        o_result.event_code       = ev;
        o_result.battery_level    = n_last[BAT_MSB:BAT_LSB];
        o_result.battery_reported = rep;
        o_result.read_error       = !i_item.clear_status && i_item.read_failed;
    end

    // Update the stored word only when the word moves on to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (i_advance) begin
            r_last <= n_last;
        end
    end

endmodule

// ===== hw/rtl/cses_out_stage.sv =====
// Result register stage feeding the master-side stream.
module cses_out_stage
    import cses_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== sim/charger_event_checker.sv =====
// Stream monitor, event predictor and result comparator for the charger status classifier.
`timescale 1ns / 100ps

module charger_event_checker
    import cses_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    // [23:0] alert_word
    input  logic [ALERT_W-1:0]    i_in_data,
    // [0] host_in_reset, [1] read_failed, [2] clear_status
    input  logic [IN_USER_W-1:0]  i_in_user,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    // [7:0] battery_level
    input  logic [BATTERY_W-1:0]  i_out_data,
    // [2:0] event_code, [3] battery_reported, [4] read_error
    input  logic [OUT_USER_W-1:0] i_out_user,
    output int                    o_mismatch_count,
    output int                    o_pending
);

    logic [ALERT_W-1:0] status_word;
    t_result            pending_events[$];
    int                 mismatch_total = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns  MISMATCH  %s", $time, msg);
        mismatch_total++;
    endtask

    function automatic logic [ALERT_W-1:0] status_after(input t_item it,
                                                       input logic [ALERT_W-1:0] prev);
        if (it.clear_status)
            return '0;
        else if (it.read_failed)
            return prev;
        return it.alert_word;
    endfunction

    function automatic t_result classify_alert(input t_item it,
                                               input logic [ALERT_W-1:0] prev);
        logic [ALERT_W-1:0] cur;
        logic [ALERT_W-1:0] kept;
        t_result            r;
        cur = it.alert_word;
        kept = status_after(it, prev);
        r.event_code = EV_NONE;
        r.battery_reported = 1'b0;
        r.read_error = 1'b0;
        r.battery_level = kept[BAT_MSB:BAT_LSB];
        // a clear request wins over everything and reports nothing
        if (!it.clear_status && it.read_failed) begin
            r.read_error = 1'b1;
        end else if (!it.clear_status) begin
            if (cur[IRQ_MSB:IRQ_LSB] == IRQ_CHIP_RESET) begin
                r.event_code = EV_RESET;
            end else if (cur[DEV_BIT] != prev[DEV_BIT]) begin
                r.event_code = cur[DEV_BIT] ? EV_CONNECTED : EV_LOST;
            end else if (cur[PROF_MSB:PROF_LSB] != prev[PROF_MSB:PROF_LSB]) begin
                r.event_code = EV_UPDATE;
                r.battery_reported = 1'b1;
            end else if (cur[CHG_BIT] != prev[CHG_BIT]) begin
                r.event_code = cur[CHG_BIT] ? EV_STARTED : EV_STOPPED;
            end else if (cur[BAT_MSB:BAT_LSB] != prev[BAT_MSB:BAT_LSB]) begin
                r.event_code = EV_UPDATE;
                r.battery_reported = 1'b1;
            end else if (it.host_in_reset) begin
                r.event_code = EV_RESET;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch_streams
        t_item   item;
        t_result want;
        t_event  got_event;
        if (!i_rst_n) begin
            status_word = '0;
            pending_events.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got_event = t_event'(i_out_user[EVENT_W-1:0]);
                if (pending_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word data=%0h user=%0h",
                                              i_out_data, i_out_user));
                end else begin
                    want = pending_events.pop_front();
                    if (got_event != want.event_code)
                        report_mismatch($sformatf("event_code got %0d want %0d",
                                                  got_event, want.event_code));
                    if (i_out_data != want.battery_level)
                        report_mismatch($sformatf("battery_level got %0h want %0h",
                                                  i_out_data, want.battery_level));
                    if (i_out_user[EVENT_W] != want.battery_reported)
                        report_mismatch($sformatf("battery_reported got %0b want %0b",
                                                  i_out_user[EVENT_W], want.battery_reported));
                    if (i_out_user[EVENT_W+1] != want.read_error)
                        report_mismatch($sformatf("read_error got %0b want %0b",
                                                  i_out_user[EVENT_W+1], want.read_error));
                end
            end
            if (i_in_valid && i_in_ready) begin
                item.alert_word = i_in_data;
                item.host_in_reset = i_in_user[0];
                item.read_failed = i_in_user[1];
                item.clear_status = i_in_user[2];
                pending_events.push_back(classify_alert(item, status_word));
                status_word = status_after(item, status_word);
            end
        end
        o_pending <= pending_events.size();
        o_mismatch_count <= mismatch_total;
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the charger status classifier simulation: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import cses_pkg::*;

    localparam logic [IN_USER_W-1:0] FLAG_NONE        = 3'b000;
    localparam logic [IN_USER_W-1:0] FLAG_HOST_RESET  = 3'b001;
    localparam logic [IN_USER_W-1:0] FLAG_READ_FAILED = 3'b010;
    localparam logic [IN_USER_W-1:0] FLAG_CLEAR       = 3'b100;
    localparam int                   RANDOM_PER_PHASE = 188;
    localparam int                   QUIET_LIMIT      = 2000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [ALERT_W-1:0]    s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [BATTERY_W-1:0]  m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    int mismatch_count;
    int pending_count;
    int sender_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    charger_status_event_classifier i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    charger_event_checker event_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (s_axis_tvalid),
        .i_in_ready       (s_axis_tready),
        .i_in_data        (s_axis_tdata),
        .i_in_user        (s_axis_tuser),
        .i_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .i_out_data       (m_axis_tdata),
        .i_out_user       (m_axis_tuser),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_count)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // end the run when neither side moves a word for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [ALERT_W-1:0] alert_of(input logic [3:0] irq,
                                                    input logic [7:0] battery,
                                                    input logic dev, input logic chg,
                                                    input logic [1:0] prof);
        logic [ALERT_W-1:0] w;
        w = '0;
        w[IRQ_MSB:IRQ_LSB] = irq;
        w[BAT_MSB:BAT_LSB] = battery;
        w[DEV_BIT] = dev;
        w[CHG_BIT] = chg;
        w[PROF_MSB:PROF_LSB] = prof;
        return w;
    endfunction

    // mostly small edits of the previous word so the lower priorities get hit
    function automatic logic [ALERT_W-1:0] next_alert(input logic [ALERT_W-1:0] prev);
        logic [ALERT_W-1:0] w;
        w = prev;
        if ($urandom_range(99) < 15) begin
            w = ALERT_W'($urandom);
        end else begin
            do begin
                case ($urandom_range(5))
                    0: w[DEV_BIT] = ~w[DEV_BIT];
                    1: w[PROF_MSB:PROF_LSB] = 2'($urandom);
                    2: w[CHG_BIT] = ~w[CHG_BIT];
                    3: w[BAT_MSB:BAT_LSB] = 8'($urandom);
                    4: begin
                        w[IRQ_LSB-1:BAT_MSB+1] = 4'($urandom);
                        w[PROF_LSB-1:0] = 4'($urandom);
                    end
                    default: ;
                endcase
            end while ($urandom_range(99) < 25);
            if ($urandom_range(99) < 30)
                w[IRQ_MSB:IRQ_LSB] = 4'($urandom);
        end
        if ($urandom_range(99) < 8)
            w[IRQ_MSB:IRQ_LSB] = IRQ_CHIP_RESET;
        else if (w[IRQ_MSB:IRQ_LSB] == IRQ_CHIP_RESET)
            w[IRQ_MSB:IRQ_LSB] = 4'($urandom_range(8));
        return w;
    endfunction

    task automatic send_word(input logic [ALERT_W-1:0] word,
                             input logic [IN_USER_W-1:0] flags);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        s_axis_tuser <= flags;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    initial begin
        logic [ALERT_W-1:0]   word;
        logic [IN_USER_W-1:0] flags;
        int                   phase;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FLAG_NONE;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each priority level, the flags and the field extremes
        send_word(alert_of(4'd0, 8'h00, 1'b0, 1'b0, 2'd0), FLAG_NONE);
        send_word(alert_of(4'd0, 8'h00, 1'b0, 1'b0, 2'd0), FLAG_HOST_RESET);
        send_word(alert_of(4'd0, 8'h00, 1'b1, 1'b0, 2'd0), FLAG_NONE);
        send_word(alert_of(4'd0, 8'h00, 1'b1, 1'b0, 2'd2), FLAG_NONE);
        send_word(alert_of(4'd0, 8'h00, 1'b1, 1'b1, 2'd2), FLAG_NONE);
        send_word(alert_of(4'd0, 8'hFF, 1'b1, 1'b1, 2'd2), FLAG_NONE);
        send_word(alert_of(4'd0, 8'hFF, 1'b1, 1'b1, 2'd2), FLAG_HOST_RESET);
        send_word(alert_of(4'd0, 8'hFF, 1'b1, 1'b0, 2'd2), FLAG_NONE);
        send_word(alert_of(4'd0, 8'hFF, 1'b0, 1'b0, 2'd2), FLAG_NONE);
        send_word(alert_of(IRQ_CHIP_RESET, 8'h12, 1'b1, 1'b1, 2'd1), FLAG_NONE);
        send_word(24'hFFFFFF, FLAG_READ_FAILED);
        send_word(24'hFFFFFF, FLAG_READ_FAILED | FLAG_CLEAR | FLAG_HOST_RESET);
        send_word(24'hFFFFFF, FLAG_NONE);
        send_word(24'hFFFFFF, FLAG_HOST_RESET);
        send_word(alert_of(IRQ_CHIP_RESET, 8'h00, 1'b0, 1'b0, 2'd0), FLAG_READ_FAILED);
        send_word(alert_of(4'd8, 8'hFF, 1'b1, 1'b1, 2'd3), FLAG_NONE);
        send_word(alert_of(4'd10, 8'hFF, 1'b1, 1'b1, 2'd3), FLAG_NONE);
        send_word(alert_of(4'd10, 8'h01, 1'b1, 1'b1, 2'd3), FLAG_NONE);
        send_word(alert_of(4'd10, 8'h01, 1'b1, 1'b1, 2'd0), FLAG_HOST_RESET);
        send_word(24'h000000, FLAG_CLEAR);
        send_word(24'h0F000F, FLAG_NONE);
        send_word(alert_of(IRQ_CHIP_RESET, 8'hA5, 1'b0, 1'b1, 2'd3), FLAG_HOST_RESET);
        send_word(alert_of(4'd0, 8'h5A, 1'b0, 1'b0, 2'd3), FLAG_HOST_RESET);
        word = alert_of(4'd0, 8'h5A, 1'b0, 1'b0, 2'd3);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct <= 0;  stall_pct <= 0;  end
                1: begin sender_idle_pct <= 59; stall_pct <= 0;  end
                2: begin sender_idle_pct <= 0;  stall_pct <= 59; end
                default: begin sender_idle_pct <= 12; stall_pct <= 12; end
            endcase
            repeat (RANDOM_PER_PHASE) begin
                word = next_alert(word);
                flags = FLAG_NONE;
                if ($urandom_range(99) < 25) flags = flags | FLAG_HOST_RESET;
                if ($urandom_range(99) < 8)  flags = flags | FLAG_READ_FAILED;
                if ($urandom_range(99) < 4)  flags = flags | FLAG_CLEAR;
                send_word(word, flags);
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
